// ----- design/ccltv_pkg.sv -----
// shared types, constants and helper functions for the codec config ltv parser
// no dependencies
`timescale 1ns / 1ps

package ccltv_pkg;

    typedef enum logic [1:0]
    {
        PH_LENGTH = 2'd0,
        PH_TYPE   = 2'd1,
        PH_VALUE  = 2'd2
    } phase_t;

    typedef struct packed
    {
        logic [5:0]  channels;
        logic [15:0] octets;
        logic [13:0] duration;
        logic [15:0] rate;
    } settings_t;

    localparam int IN_WIDTH  = 8;
    localparam int OUT_WIDTH = 56;

    localparam logic [7:0] REC_RATE     = 8'd1;
    localparam logic [7:0] REC_DURATION = 8'd2;
    localparam logic [7:0] REC_CHANNELS = 8'd3;
    localparam logic [7:0] REC_OCTETS   = 8'd4;

    localparam logic [7:0] FREQ_8K   = 8'd1;
    localparam logic [7:0] FREQ_16K  = 8'd3;
    localparam logic [7:0] FREQ_24K  = 8'd5;
    localparam logic [7:0] FREQ_32K  = 8'd6;
    localparam logic [7:0] FREQ_44K1 = 8'd7;

    localparam logic [7:0] DUR_10MS = 8'd1;

    localparam logic [15:0] RATE_8000  = 16'd8000;
    localparam logic [15:0] RATE_16000 = 16'd16000;
    localparam logic [15:0] RATE_24000 = 16'd24000;
    localparam logic [15:0] RATE_32000 = 16'd32000;
    localparam logic [15:0] RATE_44100 = 16'd44100;
    localparam logic [15:0] RATE_48000 = 16'd48000;

    localparam logic [13:0] DUR_10000 = 14'd10000;
    localparam logic [13:0] DUR_7500  = 14'd7500;

    localparam logic [5:0]  CHANNELS_DEFAULT = 6'd1;
    localparam logic [15:0] OCTETS_DEFAULT   = 16'd60;

    localparam settings_t SETTINGS_DEFAULT = '{
        channels: CHANNELS_DEFAULT,
        octets:   OCTETS_DEFAULT,
        duration: DUR_10000,
        rate:     RATE_48000
    };

    localparam logic [7:0] MAP_BYTES = 8'd4;

    function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'd0, b[i]};
        end
        return n;
    endfunction

    function automatic logic [15:0] rate_from_code(input logic [7:0] code);
        logic [15:0] r;
        case (code)
            FREQ_8K:   r = RATE_8000;
            FREQ_16K:  r = RATE_16000;
            FREQ_24K:  r = RATE_24000;
            FREQ_32K:  r = RATE_32000;
            FREQ_44K1: r = RATE_44100;
            default:   r = RATE_48000;
        endcase
        return r;
    endfunction

    function automatic settings_t commit_record(
        input logic [7:0] rec_type,
        input logic [7:0] nvals,
        input logic [7:0] low_byte,
        input logic [7:0] high_byte,
        input logic [5:0] bitcount,
        input settings_t  cur
    );
        settings_t s;
        s = cur;
        case (rec_type)
            REC_RATE:
            begin
                if (nvals != 8'd0)
                begin
                    s.rate = rate_from_code(low_byte);
                end
            end
            REC_DURATION:
            begin
                if (nvals != 8'd0)
                begin
                    s.duration = (low_byte == DUR_10MS) ? DUR_10000 : DUR_7500;
                end
            end
            REC_CHANNELS:
            begin
                s.channels = (bitcount == 6'd0) ? CHANNELS_DEFAULT : bitcount;
            end
            REC_OCTETS:
            begin
                if (nvals >= 8'd2)
                begin
                    s.octets = {high_byte, low_byte};
                end
                else if (nvals == 8'd1)
                begin
                    s.octets = {8'd0, low_byte};
                end
            end
            default:
            begin
                s = cur;
            end
        endcase
        return s;
    endfunction

endpackage

// ----- design/ccltv_parser.sv -----
// record state machine of the ltv parser, one byte per cycle while byte_valid is high
// depends on ccltv_pkg
`timescale 1ns / 1ps

module ccltv_parser
    import ccltv_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    input  logic [7:0] byte_data,
    input  logic       byte_last,
    output settings_t  result
);

    phase_t     phase_reg, phase_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] type_reg, type_next;
    logic [7:0] idx_reg, idx_next;
    logic [7:0] low_reg, low_next;
    logic [7:0] high_reg, high_next;
    logic [5:0] cnt_reg, cnt_next;
    settings_t  comm_reg, comm_next;

    always_comb
    begin
        phase_next = phase_reg;
        len_next   = len_reg;
        type_next  = type_reg;
        idx_next   = idx_reg;
        low_next   = low_reg;
        high_next  = high_reg;
        cnt_next   = cnt_reg;
        comm_next  = comm_reg;
        case (phase_reg)
            PH_LENGTH:
            begin
                len_next   = byte_data;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                type_next = byte_data;
                idx_next  = 8'd0;
                low_next  = 8'd0;
                high_next = 8'd0;
                cnt_next  = 6'd0;
                if (len_reg == 8'd0)
                begin
                    // zero length: type byte doubles as next length
                    comm_next  = commit_record(byte_data, 8'd0, 8'd0, 8'd0, 6'd0, comm_reg);
                    len_next   = byte_data;
                    phase_next = PH_TYPE;
                end
                else if (len_reg == 8'd1)
                begin
                    comm_next  = commit_record(byte_data, 8'd0, 8'd0, 8'd0, 6'd0, comm_reg);
                    phase_next = PH_LENGTH;
                end
                else
                begin
                    phase_next = PH_VALUE;
                end
            end
            PH_VALUE:
            begin
                if (idx_reg == 8'd0)
                begin
                    low_next = byte_data;
                end
                else if (idx_reg == 8'd1)
                begin
                    high_next = byte_data;
                end
                if (idx_reg < MAP_BYTES)
                begin
                    cnt_next = cnt_reg + {2'd0, ones_in_byte(byte_data)};
                end
                idx_next = idx_reg + 8'd1;
                if (idx_next >= (len_reg - 8'd1))
                begin
                    comm_next  = commit_record(type_reg, idx_next, low_next, high_next,
                                               cnt_next, comm_reg);
                    phase_next = PH_LENGTH;
                end
            end
            default:
            begin
                phase_next = PH_LENGTH;
            end
        endcase
    end

    assign result = comm_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LENGTH;
            len_reg   <= 8'd0;
            type_reg  <= 8'd0;
            idx_reg   <= 8'd0;
            low_reg   <= 8'd0;
            high_reg  <= 8'd0;
            cnt_reg   <= 6'd0;
            comm_reg  <= SETTINGS_DEFAULT;
        end
        else if (byte_valid)
        begin
            if (byte_last)
            begin
                // end of blob: back to defaults for the next one
                phase_reg <= PH_LENGTH;
                len_reg   <= 8'd0;
                type_reg  <= 8'd0;
                idx_reg   <= 8'd0;
                low_reg   <= 8'd0;
                high_reg  <= 8'd0;
                cnt_reg   <= 6'd0;
                comm_reg  <= SETTINGS_DEFAULT;
            end
            else
            begin
                phase_reg <= phase_next;
                len_reg   <= len_next;
                type_reg  <= type_next;
                idx_reg   <= idx_next;
                low_reg   <= low_next;
                high_reg  <= high_next;
                cnt_reg   <= cnt_next;
                comm_reg  <= comm_next;
            end
        end
    end

endmodule

// ----- design/ccltv_out_reg.sv -----
// result register holding one settings request until taken downstream
// depends on ccltv_pkg
`timescale 1ns / 1ps

module ccltv_out_reg
    import ccltv_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      load,
    input  settings_t load_data,
    output logic      out_valid,
    input  logic      out_ready,
    output settings_t out_data
);

    logic      valid_reg;
    settings_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ----- design/codec_config_ltv_parser_unit.sv -----
// top level of the codec config ltv parser: input register, parser, result register
// depends on ccltv_pkg, ccltv_parser, ccltv_out_reg
//
//  port group | dir | contents
//  s_*        | in  | tdata[7:0] config_byte, tlast last_byte
//  m_*        | out | tdata rate[15:0] duration[29:16] channels[35:30] octets[51:36]
//
// one byte accepted per cycle unless a last byte stalls; last byte loads m_tvalid
// the parser state only advances out of the input register; only a last byte
// waits there while the result register still holds an untaken request
// reset clears all control state and restores the default settings
`timescale 1ns / 1ps

module codec_config_ltv_parser_unit
    import ccltv_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_WIDTH-1:0]  s_tdata,   // config_byte
    input  logic                 s_tlast,   // last_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [OUT_WIDTH-1:0] m_tdata    // rate, duration,
                                            // channels, octets, zero pad
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       advance;
    settings_t  result;
    settings_t  out_data;

    assign advance  = in_valid_reg && (!in_last_reg || !m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    ccltv_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (advance),
        .byte_data  (in_byte_reg),
        .byte_last  (in_last_reg),
        .result     (result)
    );

    ccltv_out_reg u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && in_last_reg),
        .load_data (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {4'd0, out_data.octets, out_data.channels, out_data.duration,
                      out_data.rate};

`ifndef ASSERT_OFF
    a_rise_from_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(advance && in_last_reg))
        else $error("result appeared without a last byte");

    a_stall_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !advance) |-> (in_last_reg && m_tvalid && !m_tready))
        else $error("input register stalled without cause");

    a_channels_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[35:30] != 6'd0))
        else $error("zero channel count");

    a_duration_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[29:16] == DUR_10000 || m_tdata[29:16] == DUR_7500))
        else $error("illegal frame duration");
`endif

endmodule
